// ===== design/jsi_pkg.sv =====
`default_nettype none

package jsi_pkg;

    localparam int STICK_W  = 16;
    localparam int POS_W    = 32;
    localparam int VEL_W    = 17;
    localparam int DZ_W     = 15;
    localparam int COEF_W   = 16;
    localparam int BOUND_W  = 16;
    localparam int BOX_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 152;

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WS_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WS_HIGH     = 3'd7;

    localparam logic [DZ_W-1:0]   RST_DEADZONE    = 15'd2621;
    localparam logic [COEF_W-1:0] RST_GAIN_X      = 16'd5243;
    localparam logic [COEF_W-1:0] RST_GAIN_Y      = 16'd5243;
    localparam logic [COEF_W-1:0] RST_GAIN_Z      = 16'd3277;
    localparam logic [COEF_W-1:0] RST_FILTER_COEF = 16'd2114;
    localparam logic [COEF_W-1:0] RST_STEP_TIME   = 16'd1049;
    localparam logic [BOX_W-1:0]  RST_WS_LOW      = 48'd884642480947;
    localparam logic [BOX_W-1:0]  RST_WS_HIGH     = 48'd11433323727872;

    typedef struct packed {
        logic load;
        logic mul_g;
        logic mul_a;
        logic mul_t;
        logic commit;
        logic restart;
        logic engage;
        logic active;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [POS_W-1:0] target;
        logic signed [VEL_W-1:0] velocity;
    } lane_res_t;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [21:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > 22'sd65535) begin
            r = 17'sd65535;
        end else if (v < -22'sd65535) begin
            r = -17'sd65535;
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/jsi_lane.sv =====
`default_nettype none

module jsi_lane (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire jsi_pkg::lane_ctl_t                     ctl,
    input  wire logic signed [jsi_pkg::STICK_W-1:0]     stick,
    input  wire logic signed [jsi_pkg::POS_W-1:0]       meas,
    input  wire logic [jsi_pkg::COEF_W-1:0]             gain,
    input  wire logic [jsi_pkg::DZ_W-1:0]               deadzone,
    input  wire logic [jsi_pkg::COEF_W-1:0]             alpha,
    input  wire logic [jsi_pkg::COEF_W-1:0]             step_time,
    input  wire logic signed [jsi_pkg::BOUND_W-1:0]     bound_lo,
    input  wire logic signed [jsi_pkg::BOUND_W-1:0]     bound_hi,
    output jsi_pkg::lane_res_t                          res
);

    logic signed [jsi_pkg::STICK_W-1:0] stick_reg;
    logic signed [jsi_pkg::POS_W-1:0]   meas_reg;
    logic signed [32:0]                 gprod_reg;
    logic signed [34:0]                 aprod_reg;
    logic signed [33:0]                 tprod_reg;
    logic signed [jsi_pkg::VEL_W-1:0]   ynew_reg;
    logic signed [jsi_pkg::VEL_W-1:0]   filt_reg;
    logic signed [jsi_pkg::POS_W-1:0]   held_reg;

    logic [16:0]                        mag;
    logic signed [jsi_pkg::STICK_W-1:0] stick_dz;
    logic signed [jsi_pkg::VEL_W-1:0]   y0;
    logic signed [33:0]                 g_sum;
    logic signed [33:0]                 g_shift;
    logic signed [jsi_pkg::VEL_W-1:0]   raw;
    logic signed [17:0]                 diff;
    logic signed [35:0]                 a_sum;
    logic signed [35:0]                 a_shift;
    logic signed [21:0]                 y_sum;
    logic signed [jsi_pkg::VEL_W-1:0]   ynew;
    logic signed [34:0]                 t_sum;
    logic signed [34:0]                 t_shift;
    logic signed [jsi_pkg::POS_W-1:0]   held0;
    logic signed [32:0]                 p;
    logic signed [32:0]                 lo33;
    logic signed [32:0]                 hi33;
    logic signed [32:0]                 p_min;
    logic signed [32:0]                 p_clamp;
    logic signed [jsi_pkg::POS_W-1:0]   target_next;

    assign mag      = stick[15] ? (17'd0 - {stick[15], stick}) : {1'b0, stick};
    assign stick_dz = (mag < {2'b00, deadzone}) ? 16'sd0 : stick;
    assign y0       = ctl.restart ? 17'sd0 : filt_reg;

    assign g_sum   = $signed({gprod_reg[32], gprod_reg}) + 34'sd16384;
    assign g_shift = g_sum >>> 15;
    assign raw     = jsi_pkg::sat_vel(g_shift[21:0]);
    assign diff    = $signed({raw[16], raw}) - $signed({y0[16], y0});

    assign a_sum   = $signed({aprod_reg[34], aprod_reg}) + 36'sd32768;
    assign a_shift = a_sum >>> 16;
    assign y_sum   = $signed({{5{y0[16]}}, y0}) + a_shift[21:0];
    assign ynew    = jsi_pkg::sat_vel(y_sum);

    assign t_sum   = $signed({tprod_reg[33], tprod_reg}) + 35'sd524288;
    assign t_shift = t_sum >>> 20;
    assign held0   = ctl.engage ? meas_reg : held_reg;
    assign p       = $signed({held0[31], held0}) + $signed({{17{t_shift[15]}}, t_shift[15:0]});
    assign lo33    = $signed({{13{bound_lo[15]}}, bound_lo, 4'b0000});
    assign hi33    = $signed({{13{bound_hi[15]}}, bound_hi, 4'b0000});
    assign p_min   = (p > hi33) ? hi33 : p;
    assign p_clamp = (p_min < lo33) ? lo33 : p_min;

    assign target_next  = ctl.active ? p_clamp[31:0] : meas_reg;
    assign res.target   = target_next;
    assign res.velocity = ctl.active ? ynew_reg : 17'sd0;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            stick_reg <= stick_dz;
            meas_reg  <= meas;
        end
        if (ctl.mul_g) begin
            gprod_reg <= stick_reg * $signed({1'b0, gain});
        end
        if (ctl.mul_a) begin
            aprod_reg <= $signed({1'b0, alpha}) * diff;
        end
        if (ctl.mul_t) begin
            ynew_reg  <= ynew;
            tprod_reg <= ynew * $signed({1'b0, step_time});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
            held_reg <= '0;
        end else if (ctl.commit) begin
            filt_reg <= ctl.active ? ynew_reg : 17'sd0;
            held_reg <= target_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/jsi_merge.sv =====
`default_nettype none

module jsi_merge (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               commit,
    input  wire jsi_pkg::lane_res_t                 res_x,
    input  wire jsi_pkg::lane_res_t                 res_y,
    input  wire jsi_pkg::lane_res_t                 res_z,
    input  wire logic                               engaged,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic [jsi_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                    m_tuser,
    output logic                                    out_free
);

    logic                           valid_reg;
    logic [jsi_pkg::M_TDATA_W-1:0]  data_reg;
    logic                           user_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (commit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            data_reg <= {5'b00000, res_z.velocity, res_y.velocity, res_x.velocity,
                         res_z.target, res_y.target, res_x.target};
            user_reg <= engaged;
        end
    end

endmodule

`default_nettype wire

// ===== design/joystick_setpoint_integrator_unit.sv =====
`default_nettype none

// Channel  Dir  Payload (low bit up)                                  Handshake
// s_       in   tdata: stick_lateral, stick_forward, stick_vertical,  s_tvalid/s_tready
//               measured_x, measured_y, measured_z; tuser: deadman
// m_       out  tdata: target_x/y/z, velocity_x/y/z, 5 pad; tuser:     m_tvalid/m_tready
//               engaged
// cfg_     in   cfg_index, cfg_wdata                                   cfg_we
//
// Each item passes through capture, gain multiply, filter multiply, step-time
// multiply, then clamp and commit; the three multiplies chain through each lane.
// Reset clears the engaged flag, filter and held target, and the output valid.
// The commit cycle waits while an earlier result is still untaken on m_; a new
// item is taken whenever the lanes are free, even with a result pending.

module joystick_setpoint_integrator_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // stick_lateral[15:0], stick_forward[31:16], stick_vertical[47:32],
    // measured_x[79:48], measured_y[111:80], measured_z[143:112]
    input  wire logic [jsi_pkg::S_TDATA_W-1:0]          s_tdata,
    // deadman[0]
    input  wire logic                                   s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // target_x[31:0], target_y[63:32], target_z[95:64], velocity_x[112:96],
    // velocity_y[129:113], velocity_z[146:130], zero[151:147]
    output logic [jsi_pkg::M_TDATA_W-1:0]               m_tdata,
    // engaged[0]
    output logic                                        m_tuser,
    input  wire logic                                   cfg_we,
    input  wire logic [jsi_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [jsi_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_G = 3'd1;
    localparam logic [2:0] ST_MUL_A = 3'd2;
    localparam logic [2:0] ST_MUL_T = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic                           active_reg;
    logic                           pressed_reg;
    logic [jsi_pkg::DZ_W-1:0]       deadzone_reg;
    logic [jsi_pkg::COEF_W-1:0]     gain_x_reg;
    logic [jsi_pkg::COEF_W-1:0]     gain_y_reg;
    logic [jsi_pkg::COEF_W-1:0]     gain_z_reg;
    logic [jsi_pkg::COEF_W-1:0]     alpha_reg;
    logic [jsi_pkg::COEF_W-1:0]     step_reg;
    logic [jsi_pkg::BOX_W-1:0]      ws_low_reg;
    logic [jsi_pkg::BOX_W-1:0]      ws_high_reg;

    logic                           s_xfer;
    logic                           out_free;
    logic                           commit;
    jsi_pkg::lane_ctl_t             ctl;
    jsi_pkg::lane_res_t             res_x;
    jsi_pkg::lane_res_t             res_y;
    jsi_pkg::lane_res_t             res_z;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_DONE) && out_free;

    assign ctl.load    = s_xfer;
    assign ctl.mul_g   = (state_reg == ST_MUL_G);
    assign ctl.mul_a   = (state_reg == ST_MUL_A);
    assign ctl.mul_t   = (state_reg == ST_MUL_T);
    assign ctl.commit  = commit;
    assign ctl.restart = (active_reg != pressed_reg);
    assign ctl.engage  = !active_reg && pressed_reg;
    assign ctl.active  = pressed_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_xfer) begin
                state_next = ST_MUL_G;
            end
            ST_MUL_G: state_next = ST_MUL_A;
            ST_MUL_A: state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_DONE;
            ST_DONE:  if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            pressed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_xfer) begin
                pressed_reg <= s_tuser;
            end
            if (commit) begin
                active_reg <= pressed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= jsi_pkg::RST_DEADZONE;
            gain_x_reg   <= jsi_pkg::RST_GAIN_X;
            gain_y_reg   <= jsi_pkg::RST_GAIN_Y;
            gain_z_reg   <= jsi_pkg::RST_GAIN_Z;
            alpha_reg    <= jsi_pkg::RST_FILTER_COEF;
            step_reg     <= jsi_pkg::RST_STEP_TIME;
            ws_low_reg   <= jsi_pkg::RST_WS_LOW;
            ws_high_reg  <= jsi_pkg::RST_WS_HIGH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                jsi_pkg::REG_DEADZONE:    deadzone_reg <= cfg_wdata[jsi_pkg::DZ_W-1:0];
                jsi_pkg::REG_GAIN_X:      gain_x_reg   <= cfg_wdata[jsi_pkg::COEF_W-1:0];
                jsi_pkg::REG_GAIN_Y:      gain_y_reg   <= cfg_wdata[jsi_pkg::COEF_W-1:0];
                jsi_pkg::REG_GAIN_Z:      gain_z_reg   <= cfg_wdata[jsi_pkg::COEF_W-1:0];
                jsi_pkg::REG_FILTER_COEF: alpha_reg    <= cfg_wdata[jsi_pkg::COEF_W-1:0];
                jsi_pkg::REG_STEP_TIME:   step_reg     <= cfg_wdata[jsi_pkg::COEF_W-1:0];
                jsi_pkg::REG_WS_LOW:      ws_low_reg   <= cfg_wdata[jsi_pkg::BOX_W-1:0];
                jsi_pkg::REG_WS_HIGH:     ws_high_reg  <= cfg_wdata[jsi_pkg::BOX_W-1:0];
                default: ;
            endcase
        end
    end

    jsi_lane u_lane_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stick     (s_tdata[31:16]),
        .meas      (s_tdata[79:48]),
        .gain      (gain_x_reg),
        .deadzone  (deadzone_reg),
        .alpha     (alpha_reg),
        .step_time (step_reg),
        .bound_lo  (ws_low_reg[15:0]),
        .bound_hi  (ws_high_reg[15:0]),
        .res       (res_x)
    );

    jsi_lane u_lane_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stick     (s_tdata[15:0]),
        .meas      (s_tdata[111:80]),
        .gain      (gain_y_reg),
        .deadzone  (deadzone_reg),
        .alpha     (alpha_reg),
        .step_time (step_reg),
        .bound_lo  (ws_low_reg[31:16]),
        .bound_hi  (ws_high_reg[31:16]),
        .res       (res_y)
    );

    jsi_lane u_lane_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stick     (s_tdata[47:32]),
        .meas      (s_tdata[143:112]),
        .gain      (gain_z_reg),
        .deadzone  (deadzone_reg),
        .alpha     (alpha_reg),
        .step_time (step_reg),
        .bound_lo  (ws_low_reg[47:32]),
        .bound_hi  (ws_high_reg[47:32]),
        .res       (res_z)
    );

    jsi_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .commit   (commit),
        .res_x    (res_x),
        .res_y    (res_y),
        .res_z    (res_z),
        .engaged  (pressed_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .out_free (out_free)
    );

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == ST_MUL_G)
        else $error("transfer did not start lane work");

    a_engaged_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == active_reg)
        else $error("engaged flag out of step with held state");

    a_idle_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[146:96] == 51'd0)
        else $error("velocity nonzero while disengaged");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result without finished item");
`endif

endmodule

`default_nettype wire
